[rtl/srir_pkg.sv]
// Shared types, action codes and defaults for the sample ring interpolated read unit.
package srir_pkg;

    localparam int DEPTH_DEF    = 65536;
    localparam int TAG_BITS_DEF = 16;

    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_SEEK   = 2'd1;
    localparam logic [1:0] ACT_INTERP = 2'd2;
    localparam logic [1:0] ACT_OFFSET = 2'd3;

    typedef struct packed {
        logic clr;       // write zero at clear address, advance it
        logic capture;   // latch request fields
        logic push;      // store sample/tag at pointer, advance pointer
        logic red1;      // reciprocal multiply
        logic red2;      // quotient times depth
        logic red3;      // remainder with one correction
        logic seek;      // load pointer from remainder
        logic rd;        // read entry at reduced address
        logic rd_up;     // read the following entry
        logic lo_cap;    // hold lower sample
        logic blend;     // weighted sum
        logic out_load;  // load output register
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] action;
    } t_stat;

endpackage

[rtl/srir_ctrl.sv]
// Sequencer for the sample ring: clearing pass, request handshake, step order.
module srir_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_action,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  srir_pkg::t_stat      i_stat,
    output srir_pkg::t_cmd       o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PUSH  = 4'd2;
    localparam logic [3:0] S_RED1  = 4'd3;
    localparam logic [3:0] S_RED2  = 4'd4;
    localparam logic [3:0] S_RED3  = 4'd5;
    localparam logic [3:0] S_RD0   = 4'd6;
    localparam logic [3:0] S_RD1   = 4'd7;
    localparam logic [3:0] S_BLEND = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    srir_pkg::t_cmd w_cmd;

    always_comb begin
        n_state    = r_state;
        w_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state = (i_action == srir_pkg::ACT_PUSH) ? S_PUSH : S_RED1;
                end
            end
            S_PUSH: begin
                w_cmd.push = 1'b1;
                n_state    = S_DONE;
            end
            S_RED1: begin
                w_cmd.red1 = 1'b1;
                n_state    = S_RED2;
            end
            S_RED2: begin
                w_cmd.red2 = 1'b1;
                n_state    = S_RED3;
            end
            S_RED3: begin
                w_cmd.red3 = 1'b1;
                if (i_stat.action == srir_pkg::ACT_SEEK) begin
                    w_cmd.seek = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                w_cmd.rd = 1'b1;
                n_state  = (i_stat.action == srir_pkg::ACT_INTERP) ? S_RD1 : S_DONE;
            end
            S_RD1: begin
                w_cmd.rd_up  = 1'b1;
                w_cmd.lo_cap = 1'b1;
                n_state      = S_BLEND;
            end
            S_BLEND: begin
                w_cmd.blend = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_out_valid = r_out_valid;

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // a push reaches the store in the cycle after acceptance
    a_push_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_action == srir_pkg::ACT_PUSH) |=> w_cmd.push)
        else $error("push not issued after acceptance");

    // loading a result leaves it presented and the unit ready for the next request
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> (o_out_valid && o_in_ready))
        else $error("result load did not return to idle with valid output");

endmodule

[rtl/srir_dpath.sv]
// Datapath for the sample ring: stores, pointer, modulo reduction and interpolation.
module srir_dpath #(
    parameter int DEPTH    = srir_pkg::DEPTH_DEF,
    parameter int TAG_BITS = srir_pkg::TAG_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  srir_pkg::t_cmd        i_cmd,
    output srir_pkg::t_stat       o_stat,
    input  logic [1:0]            i_action,
    input  logic signed [15:0]    i_sample_in,
    input  logic [15:0]           i_tag_in,
    input  logic [15:0]           i_position_int,
    input  logic [15:0]           i_position_frac,
    input  logic signed [15:0]    i_read_offset,
    output logic signed [15:0]    o_sample_out,
    output logic [15:0]           o_tag_out,
    output logic [15:0]           o_pointer_out
);

    localparam int AW = $clog2(DEPTH);
    // bias so that pointer plus a negative offset stays non-negative
    localparam int KOFF = ((32768 + DEPTH - 1) / DEPTH) * DEPTH;
    localparam int XW = $clog2(2 * DEPTH + 65536);
    localparam longint unsigned MREC = (64'd1 << XW) / DEPTH;

    localparam logic [XW-1:0] DV   = XW'(DEPTH);
    localparam logic [XW-1:0] KV   = XW'(KOFF);
    localparam logic [XW-1:0] MV   = XW'(MREC);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic signed [15:0] r_sample_mem [DEPTH];
    logic [TAG_BITS-1:0] r_tag_mem   [DEPTH];

    logic [AW-1:0]       r_ptr;
    logic [AW-1:0]       r_clr_addr;
    logic [1:0]          r_action;
    logic signed [15:0]  r_sample;
    logic [TAG_BITS-1:0] r_tag;
    logic [15:0]         r_frac;
    logic [XW-1:0]       r_x;
    logic [2*XW-1:0]     r_prod1;
    logic [XW-1:0]       r_qd;
    logic [AW-1:0]       r_addr;
    logic signed [15:0]  r_rd_sample;
    logic [TAG_BITS-1:0] r_rd_tag;
    logic signed [15:0]  r_lo;
    logic signed [33:0]  r_blend;
    logic signed [15:0]  r_sample_out;
    logic [15:0]         r_tag_out;
    logic [15:0]         r_pointer_out;

    logic [XW-1:0]       n_x;
    logic [XW-1:0]       w_diff;
    logic [AW-1:0]       n_rem;
    logic [AW-1:0]       w_upper;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr;
    logic                w_we;
    logic signed [15:0]  w_wsample;
    logic [TAG_BITS-1:0] w_wtag;
    logic signed [16:0]  w_delta;
    logic signed [33:0]  n_blend;
    logic signed [33:0]  w_round;
    logic signed [15:0]  n_sample_out;
    logic [15:0]         n_tag_out;

    always_comb begin
        if (i_action == srir_pkg::ACT_OFFSET) begin
            n_x = XW'(r_ptr) + KV + XW'(i_read_offset);
        end else begin
            n_x = XW'(i_position_int);
        end
    end

    // quotient estimate is exact or one low; a single subtract corrects it
    assign w_diff = r_x - r_qd;
    assign n_rem  = (w_diff >= DV) ? AW'(w_diff - DV) : AW'(w_diff);

    assign w_upper   = (r_addr == LAST) ? '0 : r_addr + AW'(1);
    assign w_we      = i_cmd.clr | i_cmd.push;
    assign w_waddr   = i_cmd.clr ? r_clr_addr : r_ptr;
    assign w_wsample = i_cmd.clr ? 16'sd0 : r_sample;
    assign w_wtag    = i_cmd.clr ? '0 : r_tag;
    assign w_raddr   = i_cmd.rd_up ? w_upper : r_addr;

    // lo*(1-f) + hi*f == lo*2^16 + (hi-lo)*f
    assign w_delta = 17'(r_rd_sample) - 17'(r_lo);
    assign n_blend = ($signed({{2{r_lo[15]}}, r_lo, 16'h0000}))
                   + (w_delta * $signed({1'b0, r_frac}));
    assign w_round = r_blend + 34'sd32768;

    always_comb begin
        n_sample_out = 16'sd0;
        n_tag_out    = 16'h0000;
        unique case (r_action)
            srir_pkg::ACT_INTERP: n_sample_out = w_round[31:16];
            srir_pkg::ACT_OFFSET: begin
                n_sample_out = r_rd_sample;
                n_tag_out    = 16'(32'(r_rd_tag));
            end
            default: begin
                n_sample_out = 16'sd0;
                n_tag_out    = 16'h0000;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_sample_mem[w_waddr] <= w_wsample;
            r_tag_mem[w_waddr]    <= w_wtag;
        end
        if (i_cmd.rd || i_cmd.rd_up) begin
            r_rd_sample <= r_sample_mem[w_raddr];
            r_rd_tag    <= r_tag_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_clr_addr <= '0;
            r_action   <= srir_pkg::ACT_PUSH;
        end else begin
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cmd.capture) r_action <= i_action;
            if (i_cmd.push) begin
                r_ptr <= (r_ptr == LAST) ? '0 : r_ptr + AW'(1);
            end else if (i_cmd.seek) begin
                r_ptr <= n_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample_in;
            r_tag    <= TAG_BITS'(32'(i_tag_in));
            r_frac   <= i_position_frac;
            r_x      <= n_x;
        end
        if (i_cmd.red1) r_prod1 <= (2*XW)'(r_x) * (2*XW)'(MV);
        if (i_cmd.red2) r_qd <= XW'(r_prod1[2*XW-1:XW] * DV);
        if (i_cmd.red3) r_addr <= n_rem;
        if (i_cmd.lo_cap) r_lo <= r_rd_sample;
        if (i_cmd.blend) r_blend <= n_blend;
        if (i_cmd.out_load) begin
            r_sample_out  <= n_sample_out;
            r_tag_out     <= n_tag_out;
            r_pointer_out <= 16'(32'(r_ptr));
        end
    end

    assign o_stat.clr_last = (r_clr_addr == LAST);
    assign o_stat.action   = r_action;
    assign o_sample_out    = r_sample_out;
    assign o_tag_out       = r_tag_out;
    assign o_pointer_out   = r_pointer_out;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push || i_cmd.seek) |=> (r_ptr <= LAST))
        else $error("write pointer left the ring");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.red3 |=> (r_addr <= LAST))
        else $error("reduced address out of range");

endmodule

[rtl/sample_ring_interpolated_read_unit.sv]
// Top level of the sample ring with interpolated and offset reads.
// Usage:
//   Input channel i_in_valid/o_in_ready carries one request: an action
//   (push, seek, interpolated read, offset read) and its fields. Output
//   channel o_out_valid/i_out_ready returns exactly one result per request:
//   sample, tag and the write pointer after the request.
//   Requests are handled one at a time. The time from acceptance until the
//   result is presented and the spacing of accepted requests are set by the
//   sequencer order, by the reciprocal modulo unit with its multiply,
//   quotient-times-depth and correction steps, and by the single read port
//   of the sample store, which fetches the two neighbors of an
//   interpolation in turn.
//   After reset both stores are zeroed by a clearing pass over all DEPTH
//   entries, one entry a cycle; o_in_ready stays low until it completes.
//   A finished result sits in the output register; the next request is
//   still accepted and worked on, and waits only at its own result if the
//   receiver holds i_out_ready low.
module sample_ring_interpolated_read_unit #(
    parameter int DEPTH    = srir_pkg::DEPTH_DEF,
    parameter int TAG_BITS = srir_pkg::TAG_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_sample_in,
    input  logic [15:0]        i_tag_in,
    input  logic [15:0]        i_position_int,
    input  logic [15:0]        i_position_frac,
    input  logic signed [15:0] i_read_offset,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample_out,
    output logic [15:0]        o_tag_out,
    output logic [15:0]        o_pointer_out
);

    srir_pkg::t_cmd  w_cmd;
    srir_pkg::t_stat w_stat;

    srir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    srir_dpath #(
        .DEPTH    (DEPTH),
        .TAG_BITS (TAG_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_action        (i_action),
        .i_sample_in     (i_sample_in),
        .i_tag_in        (i_tag_in),
        .i_position_int  (i_position_int),
        .i_position_frac (i_position_frac),
        .i_read_offset   (i_read_offset),
        .o_sample_out    (o_sample_out),
        .o_tag_out       (o_tag_out),
        .o_pointer_out   (o_pointer_out)
    );

endmodule
